### design/ukq_pkg.sv
`default_nettype none

package ukq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int ENTRY_W     = 5;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] item_key;
        logic signed [DATA_W-1:0] item_value;
    } in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] out_key;
        logic signed [DATA_W-1:0] out_value;
        logic [ENTRY_W-1:0]       entry_count;
        logic                     is_empty;
    } out_t;

endpackage

`default_nettype wire

### design/unique_key_fifo_queue.sv
`default_nettype none
// Enqueue: the item enters S_SCAN, where one comparator walks the held keys one slot a
// cycle from the head, then S_DONE loads the result register; a duplicate hit ends early.
// Dequeue: S_DEQ waits on the registered store read of the head; empty goes to S_DONE.
// One item in flight: s_ready returns as the result register loads, and an untaken
// result holds the sequencer in its last state.
// Reset (aresetn, synchronous, active low) clears head/tail pointers, count and control only.
module unique_key_fifo_queue (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire ukq_pkg::in_t s_data,
    output logic              m_valid,
    input  wire logic         m_ready,
    output ukq_pkg::out_t     m_data
);
    import ukq_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;  // duplicate search over held keys
    localparam logic [1:0] S_DEQ  = 2'd2;  // head read in flight
    localparam logic [1:0] S_DONE = 2'd3;  // commit and load result

    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_CNT  = COUNT_W'(QUEUE_DEPTH);

    // ring store
    logic signed [DATA_W-1:0] key_mem [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] val_mem [QUEUE_DEPTH];
    logic signed [DATA_W-1:0] key_rd_reg;
    logic signed [DATA_W-1:0] val_rd_reg;
    logic                     mem_we;

    logic [1:0]         state_reg,   state_next;
    logic [IDX_W-1:0]   head_reg,    head_next;
    logic [IDX_W-1:0]   tail_reg,    tail_next;
    logic [COUNT_W-1:0] occ_reg,     occ_next;
    logic [IDX_W-1:0]   rd_ptr_reg,  rd_ptr_next;
    logic [COUNT_W-1:0] rd_cnt_reg,  rd_cnt_next;
    logic               pend_reg,    pend_next;   // read data awaits compare
    logic               dup_reg,     dup_next;
    in_t                item_reg,    item_next;
    logic               m_valid_reg, m_valid_next;
    out_t               m_data_reg,  m_data_next;

    logic [COUNT_W+ENTRY_W-1:0] occ_wide;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[tail_reg] <= item_reg.item_key;
            val_mem[tail_reg] <= item_reg.item_value;
        end
        key_rd_reg <= key_mem[rd_ptr_reg];
        val_rd_reg <= val_mem[rd_ptr_reg];
    end

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        rd_ptr_next  = rd_ptr_reg;
        rd_cnt_next  = rd_cnt_reg;
        pend_next    = pend_reg;
        dup_next     = dup_reg;
        item_next    = item_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        occ_wide     = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    item_next   = s_data;
                    rd_ptr_next = head_reg;
                    rd_cnt_next = '0;
                    pend_next   = 1'b0;
                    dup_next    = 1'b0;
                    if (s_data.opcode == OP_ENQ) begin
                        state_next = S_SCAN;
                    end else if (occ_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_DEQ;
                    end
                end
            end
            S_SCAN: begin
                // compare the slot read last cycle while the next read issues
                if (pend_reg && (key_rd_reg == item_reg.item_key)) begin
                    dup_next   = 1'b1;
                    state_next = S_DONE;
                end else if (rd_cnt_reg < occ_reg) begin
                    rd_ptr_next = wrap_inc(rd_ptr_reg);
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    pend_next   = 1'b1;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DEQ: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.status    = ST_OK;
                    m_data_next.out_key   = '0;
                    m_data_next.out_value = '0;
                    if (item_reg.opcode == OP_ENQ) begin
                        if (dup_reg) begin
                            m_data_next.status = ST_DUP;
                        end else if (occ_reg == FULL_CNT) begin
                            m_data_next.status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            tail_next = wrap_inc(tail_reg);
                            occ_next  = occ_reg + 1'b1;
                        end
                    end else begin
                        if (occ_reg == '0) begin
                            m_data_next.status = ST_EMPTY;
                        end else begin
                            m_data_next.out_key   = key_rd_reg;
                            m_data_next.out_value = val_rd_reg;
                            head_next = wrap_inc(head_reg);
                            occ_next  = occ_reg - 1'b1;
                        end
                    end
                    occ_wide                = {{ENTRY_W{1'b0}}, occ_next};
                    m_data_next.entry_count = occ_wide[ENTRY_W-1:0];
                    m_data_next.is_empty    = (occ_next == '0);
                    m_valid_next            = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            pend_reg    <= 1'b0;
            dup_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            pend_reg    <= pend_next;
            dup_reg     <= dup_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and scan pointers need no reset
    always_ff @(posedge aclk) begin
        rd_ptr_reg <= rd_ptr_next;
        rd_cnt_reg <= rd_cnt_next;
        item_reg   <= item_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire
